### hdl/psfx_pkg.sv
// Shared types, constants and helper functions of the procedural sound synthesizer.
`default_nettype none

package psfx_pkg;

    // Resolution of the sine and exponential approximations (powers of two).
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int EXP_TABLE_DEPTH  = 1024;
    localparam int SINE_BITS        = $clog2(SINE_TABLE_DEPTH);
    localparam int EXP_BITS         = $clog2(EXP_TABLE_DEPTH);

    // Field widths.
    localparam int INDEX_W  = 17;
    localparam int SAMPLE_W = 16;
    localparam int LFSR_W   = 32;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int Q_W      = 21;
    localparam int REM_W    = 17;

    // Sound lengths and timing constants.
    localparam logic [INDEX_W-1:0] GUN_LEN        = 17'd44100;
    localparam logic [INDEX_W-1:0] GROWL_LEN      = 17'd88200;
    localparam logic [INDEX_W-1:0] RAMP_UP_END    = 17'd4410;
    localparam logic [INDEX_W-1:0] RAMP_DOWN_BEG  = 17'd66150;
    localparam logic [14:0]        ENV_FULL       = 15'd22050;

    // Noise generator.
    localparam logic [LFSR_W-1:0] LFSR_SEED = 32'd1;
    localparam logic [LFSR_W-1:0] LFSR_MASK = 32'hD0000001;

    // Sound selection codes.
    localparam logic ACT_GUNSHOT = 1'b0;
    localparam logic ACT_GROWL   = 1'b1;

    // Constant divisors handled by the reciprocal divide sequence.
    typedef enum logic [2:0] {
        DIV_RATE,
        DIV_NOISE,
        DIV_GUN_SCALE,
        DIV_ENV,
        DIV_GROWL_SCALE
    } div_sel_t;

    localparam logic [16:0] D_RATE        = 17'd44100;
    localparam logic [16:0] D_NOISE       = 17'd2000;
    localparam logic [16:0] D_GUN_SCALE   = 17'd10000;
    localparam logic [16:0] D_ENV         = 17'd22050;
    localparam logic [16:0] D_GROWL_SCALE = 17'd100000;

    localparam logic [31:0] R_RATE        = 32'((64'd1 << 32) / 64'd44100);
    localparam logic [31:0] R_NOISE       = 32'((64'd1 << 32) / 64'd2000);
    localparam logic [31:0] R_GUN_SCALE   = 32'((64'd1 << 32) / 64'd10000);
    localparam logic [31:0] R_ENV         = 32'((64'd1 << 32) / 64'd22050);
    localparam logic [31:0] R_GROWL_SCALE = 32'((64'd1 << 32) / 64'd100000);

    // Operand pair handed to the shared multiplier.
    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE,
        ST_START,
        ST_DQ, ST_DR, ST_DC,
        ST_SN0, ST_SN1, ST_SN2, ST_SN3, ST_SN4,
        ST_EX0, ST_EX1, ST_EX2, ST_EX3, ST_EX4,
        ST_G_IDX, ST_G_SIN, ST_G_EXPK, ST_G_EXP, ST_G_NOISE, ST_G_MIX, ST_G_A,
        ST_W1, ST_W2, ST_W3, ST_W4, ST_W5, ST_W6, ST_W7, ST_W8, ST_W9, ST_W10, ST_W11,
        ST_FIN
    } state_t;

    function automatic logic [16:0] div_const(div_sel_t sel);
        logic [16:0] d;
        unique case (sel)
            DIV_RATE:        d = D_RATE;
            DIV_NOISE:       d = D_NOISE;
            DIV_GUN_SCALE:   d = D_GUN_SCALE;
            DIV_ENV:         d = D_ENV;
            DIV_GROWL_SCALE: d = D_GROWL_SCALE;
            default:         d = D_RATE;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] div_recip(div_sel_t sel);
        logic [31:0] r;
        unique case (sel)
            DIV_RATE:        r = R_RATE;
            DIV_NOISE:       r = R_NOISE;
            DIV_GUN_SCALE:   r = R_GUN_SCALE;
            DIV_ENV:         r = R_ENV;
            DIV_GROWL_SCALE: r = R_GROWL_SCALE;
            default:         r = R_RATE;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/psfx_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
`default_nettype none

module psfx_mul (
    input  wire logic                    aclk,
    input  wire psfx_pkg::mul_req_t      req,
    output logic [psfx_pkg::PROD_W-1:0]  prod
);
    import psfx_pkg::*;

    // One product per cycle; the sequencer reads it in the following state.
    always_ff @(posedge aclk) begin
        prod <= PROD_W'(req.a) * PROD_W'(req.b);
    end

endmodule

`default_nettype wire

### hdl/psfx_lfsr.sv
// Galois LFSR that supplies one noise word per synthesized sample.
`default_nettype none

module psfx_lfsr (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    step,
    output logic [psfx_pkg::LFSR_W-1:0]  next_value
);
    import psfx_pkg::*;

    logic [LFSR_W-1:0] lfsr_reg;
    logic [LFSR_W-1:0] lfsr_next;

    // Shift right and fold in the tap mask when a one drops out.
    always_comb begin
        next_value = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_MASK) : (lfsr_reg >> 1);
        lfsr_next  = step ? next_value : lfsr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg <= LFSR_SEED;
        end else begin
            lfsr_reg <= lfsr_next;
        end
    end

endmodule

`default_nettype wire

### hdl/procedural_sound_effect_synth.sv
// Top level: sequencer and datapath of the procedural sound-effect synthesizer.
//
// Each accepted transaction names a sound (gunshot or growl) and a sample index and returns
// one saturated signed 16-bit sample. The wide products run on a single 32x32 multiplier that a
// small sequencer drives step by step: sine and exponential approximations, divisions by
// constants through reciprocal multiply and correction, and the final scaling. Each division
// by a constant runs through ST_DQ, ST_DR and ST_DC, each sine through ST_SN0 to ST_SN4 and
// each exponential through ST_EX0 to ST_EX4. An index past the end of its sound returns 0
// with past_end set straight from ST_START. The input is not ready while a sample is in
// progress and is ready again in the cycle after the result is written, so a new transaction
// is taken only once the previous result is written. A finished result waits in the output
// register, and the sequencer holds its last step until that register is free.
`default_nettype none

module procedural_sound_effect_synth (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_action,
    input  wire logic [psfx_pkg::INDEX_W-1:0]   s_sample_index,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [psfx_pkg::SAMPLE_W-1:0] m_sample_value,
    output logic                                m_past_end
);
    import psfx_pkg::*;

    // Control registers.
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   m_valid_reg, m_valid_next;

    // Datapath registers.
    logic                 action_reg, action_next;
    logic [INDEX_W-1:0]   index_reg, index_next;
    div_sel_t             div_sel_reg, div_sel_next;
    logic [31:0]          div_x_reg, div_x_next;
    logic [Q_W-1:0]       q_reg, q_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [SINE_BITS-1:0] sidx_reg, sidx_next;
    logic [14:0]          x_reg, x_next;
    logic [14:0]          x2_reg, x2_next;
    logic [1:0]           quad_reg, quad_next;
    logic signed [15:0]   sin_reg, sin_next;
    logic [EXP_BITS-1:0]  k_reg, k_next;
    logic [4:0]           n_reg, n_next;
    logic [15:0]          y_reg, y_next;
    logic [14:0]          e_reg, e_next;
    logic [14:0]          env_reg, env_next;
    logic                 mneg_reg, mneg_next;
    logic [15:0]          plo_reg, plo_next;
    logic [44:0]          t_reg, t_next;
    logic [15:0]          x1lo_reg, x1lo_next;
    logic [15:0]          qh_reg, qh_next;
    logic signed [15:0]   out_val_reg, out_val_next;
    logic                 out_end_reg, out_end_next;

    // Shared units.
    mul_req_t            mreq;
    logic [PROD_W-1:0]   prod;
    logic                lfsr_step;
    logic [LFSR_W-1:0]   lfsr_value;

    // Combinational helpers.
    logic [15:0]        u_w;
    logic [14:0]        xs_w;
    logic [14:0]        x2_w;
    logic [16:0]        sa_w, sb_w, sp_w;
    logic [14:0]        sin_mag_w;
    logic signed [15:0] sin_w;
    logic [20:0]        es_w;
    logic [16:0]        ea_w, eb_w, ev_w, esh_w, er_w;
    logic [14:0]        e_w;
    logic signed [11:0] noise_w;
    logic signed [31:0] gmix_w, wmix_w, mix_w;
    logic [31:0]        mag_w;
    logic [58:0]        ga_w;
    logic [44:0]        wt_w;
    logic [59:0]        wx_w;
    logic signed [23:0] fq_w;
    logic [14:0]        env_w;
    logic [16:0]        dconst_w;
    logic [31:0]        dd_w;
    logic               dge_w;
    logic               out_free_w;
    logic               gun_end_w, growl_end_w;
    logic signed [15:0] fin_w;

    psfx_mul u_mul (
        .aclk (aclk),
        .req  (mreq),
        .prod (prod)
    );

    psfx_lfsr u_lfsr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (lfsr_step),
        .next_value (lfsr_value)
    );

    // Sine approximation: quadrant fold and polynomial terms.
    assign u_w       = {sidx_reg, {(16 - SINE_BITS){1'b0}}};
    assign xs_w      = u_w[14] ? 15'(15'd16384 - {1'b0, u_w[13:0]}) : {1'b0, u_w[13:0]};
    assign x2_w      = prod[28:14];
    assign sa_w      = 17'd42334 - prod[30:14];
    assign sb_w      = 17'd102944 - prod[30:14];
    assign sp_w      = 17'((18'(prod[30:14]) + 18'd1) >> 1);
    assign sin_mag_w = (sp_w > 17'd32767) ? 15'h7FFF : sp_w[14:0];
    assign sin_w     = quad_reg[1] ? 16'(16'd0 - {1'b0, sin_mag_w}) : {1'b0, sin_mag_w};

    // Exponential decay approximation.
    assign es_w  = 21'(prod >> EXP_BITS);
    assign ea_w  = 17'd15744 - prod[32:16];
    assign eb_w  = 17'd45426 - prod[32:16];
    assign ev_w  = 17'd65536 - prod[32:16];
    assign esh_w = ev_w >> n_reg;
    assign er_w  = 17'((18'(esh_w) + 18'd1) >> 1);
    assign e_w   = (er_w > 17'd32767) ? 15'h7FFF : er_w[14:0];

    // Noise and tone mix for both sounds.
    assign noise_w = $signed({1'b0, rem_reg[10:0]}) - 12'sd1000;
    assign gmix_w  = (32'(noise_w) <<< 18) + 32'(sin_reg) * 32'sd1000;
    assign wmix_w  = (32'(noise_w) <<< 17) + 32'(sin_reg) * 32'sd6000;
    assign mix_w   = (action_reg == ACT_GROWL) ? wmix_w : gmix_w;
    assign mag_w   = mix_w[31] ? 32'(-mix_w) : 32'(mix_w);

    // Scaling by 32767 and by 98301 with shifts, adds and subtracts.
    assign ga_w = {prod[43:0], 15'd0} - 59'(prod[43:0]);
    assign wt_w = {prod[43:0], 1'b0} + 45'(prod[43:0]);
    assign wx_w = {t_reg, 15'd0} - 60'(t_reg);

    // Growl frequency and envelope.
    assign fq_w = 24'sd5242880 + 24'(sin_reg) * 24'sd40;
    always_comb begin
        if (index_reg < RAMP_UP_END) begin
            env_w = 15'(index_reg * 17'd5);
        end else if (index_reg > RAMP_DOWN_BEG) begin
            env_w = 15'(GROWL_LEN - index_reg);
        end else begin
            env_w = ENV_FULL;
        end
    end

    // Divide correction: remainder and one conditional subtract.
    assign dconst_w = div_const(div_sel_reg);
    assign dd_w     = div_x_reg - prod[31:0];
    assign dge_w    = dd_w >= 32'(dconst_w);

    assign out_free_w  = !m_valid_reg || m_ready;
    assign gun_end_w   = index_reg >= GUN_LEN;
    assign growl_end_w = index_reg >= GROWL_LEN;

    // Sign and saturation of the final magnitude.
    always_comb begin
        if (!mneg_reg) begin
            fin_w = (q_reg > 21'd32767) ? 16'sh7FFF : $signed({1'b0, q_reg[14:0]});
        end else begin
            fin_w = (q_reg > 21'd32768) ? 16'sh8000 : $signed(16'(~q_reg[15:0] + 16'd1));
        end
    end

    // Next state, multiplier operands and datapath updates.
    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        m_valid_next = m_valid_reg;
        action_next  = action_reg;
        index_next   = index_reg;
        div_sel_next = div_sel_reg;
        div_x_next   = div_x_reg;
        q_next       = q_reg;
        rem_next     = rem_reg;
        sidx_next    = sidx_reg;
        x_next       = x_reg;
        x2_next      = x2_reg;
        quad_next    = quad_reg;
        sin_next     = sin_reg;
        k_next       = k_reg;
        n_next       = n_reg;
        y_next       = y_reg;
        e_next       = e_reg;
        env_next     = env_reg;
        mneg_next    = mneg_reg;
        plo_next     = plo_reg;
        t_next       = t_reg;
        x1lo_next    = x1lo_reg;
        qh_next      = qh_reg;
        out_val_next = out_val_reg;
        out_end_next = out_end_reg;
        mreq         = '0;
        lfsr_step    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    action_next = s_action;
                    index_next  = s_sample_index;
                    state_next  = ST_START;
                end
            end

            ST_START: begin
                mreq.a = 32'(index_reg);
                mreq.b = 32'd46501;
                if ((action_reg == ACT_GUNSHOT && gun_end_w) ||
                    (action_reg == ACT_GROWL && growl_end_w)) begin
                    if (out_free_w) begin
                        out_val_next = '0;
                        out_end_next = 1'b1;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else if (action_reg == ACT_GUNSHOT) begin
                    div_x_next   = 32'(index_reg) * 32'd150;
                    div_sel_next = DIV_RATE;
                    ret_next     = ST_G_IDX;
                    state_next   = ST_DQ;
                end else begin
                    state_next = ST_W1;
                end
            end

            // Division by a constant: reciprocal estimate, remainder, correction.
            ST_DQ: begin
                mreq.a     = div_x_reg;
                mreq.b     = div_recip(div_sel_reg);
                state_next = ST_DR;
            end
            ST_DR: begin
                q_next     = prod[32 +: Q_W];
                mreq.a     = 32'(prod[32 +: Q_W]);
                mreq.b     = 32'(dconst_w);
                state_next = ST_DC;
            end
            ST_DC: begin
                if (dge_w) begin
                    q_next   = q_reg + 21'd1;
                    rem_next = REM_W'(dd_w - 32'(dconst_w));
                end else begin
                    rem_next = REM_W'(dd_w);
                end
                state_next = ret_reg;
            end

            // Sine of the phase index in sidx_reg.
            ST_SN0: begin
                quad_next  = u_w[15:14];
                x_next     = xs_w;
                mreq.a     = 32'(xs_w);
                mreq.b     = 32'(xs_w);
                state_next = ST_SN1;
            end
            ST_SN1: begin
                x2_next    = x2_w;
                mreq.a     = 32'(x2_w);
                mreq.b     = 32'd5223;
                state_next = ST_SN2;
            end
            ST_SN2: begin
                mreq.a     = 32'(sa_w);
                mreq.b     = 32'(x2_reg);
                state_next = ST_SN3;
            end
            ST_SN3: begin
                mreq.a     = 32'(sb_w);
                mreq.b     = 32'(x_reg);
                state_next = ST_SN4;
            end
            ST_SN4: begin
                sin_next   = sin_w;
                state_next = ret_reg;
            end

            // Decay exp(-20t) for the table position in k_reg.
            ST_EX0: begin
                mreq.a     = 32'(k_reg);
                mreq.b     = 32'd1890969;
                state_next = ST_EX1;
            end
            ST_EX1: begin
                n_next     = es_w[20:16];
                y_next     = es_w[15:0];
                mreq.a     = 32'(es_w[15:0]);
                mreq.b     = 32'd3638;
                state_next = ST_EX2;
            end
            ST_EX2: begin
                mreq.a     = 32'(ea_w);
                mreq.b     = 32'(y_reg);
                state_next = ST_EX3;
            end
            ST_EX3: begin
                mreq.a     = 32'(eb_w);
                mreq.b     = 32'(y_reg);
                state_next = ST_EX4;
            end
            ST_EX4: begin
                e_next     = e_w;
                state_next = ret_reg;
            end

            // Gunshot sequence.
            ST_G_IDX: begin
                div_x_next = 32'({rem_reg[15:0], {SINE_BITS{1'b0}}});
                ret_next   = ST_G_SIN;
                state_next = ST_DQ;
            end
            ST_G_SIN: begin
                sidx_next  = q_reg[SINE_BITS-1:0];
                ret_next   = ST_G_EXPK;
                state_next = ST_SN0;
            end
            ST_G_EXPK: begin
                div_x_next = 32'({index_reg, {EXP_BITS{1'b0}}});
                ret_next   = ST_G_EXP;
                state_next = ST_DQ;
            end
            ST_G_EXP: begin
                k_next     = q_reg[EXP_BITS-1:0];
                ret_next   = ST_G_NOISE;
                state_next = ST_EX0;
            end
            ST_G_NOISE: begin
                lfsr_step    = 1'b1;
                div_x_next   = {1'b0, lfsr_value[30:0]};
                div_sel_next = DIV_NOISE;
                ret_next     = ST_G_MIX;
                state_next   = ST_DQ;
            end
            ST_G_MIX: begin
                mneg_next  = mix_w[31];
                mreq.a     = mag_w;
                mreq.b     = 32'(e_reg);
                state_next = ST_G_A;
            end
            ST_G_A: begin
                div_x_next   = 32'(ga_w[58:31]);
                div_sel_next = DIV_GUN_SCALE;
                ret_next     = ST_FIN;
                state_next   = ST_DQ;
            end

            // Growl sequence.
            ST_W1: begin
                sidx_next  = prod[31 -: SINE_BITS];
                ret_next   = ST_W2;
                state_next = ST_SN0;
            end
            ST_W2: begin
                mreq.a     = 32'(fq_w[22:0]);
                mreq.b     = 32'(index_reg);
                state_next = ST_W3;
            end
            ST_W3: begin
                plo_next     = prod[15:0];
                div_x_next   = 32'(prod[39:16]);
                div_sel_next = DIV_RATE;
                ret_next     = ST_W4;
                state_next   = ST_DQ;
            end
            ST_W4: begin
                div_x_next = {rem_reg[15:0], plo_reg};
                ret_next   = ST_W5;
                state_next = ST_DQ;
            end
            ST_W5: begin
                sidx_next  = q_reg[15 -: SINE_BITS];
                ret_next   = ST_W6;
                state_next = ST_SN0;
            end
            ST_W6: begin
                env_next     = env_w;
                lfsr_step    = 1'b1;
                div_x_next   = {1'b0, lfsr_value[30:0]};
                div_sel_next = DIV_NOISE;
                ret_next     = ST_W7;
                state_next   = ST_DQ;
            end
            ST_W7: begin
                mneg_next  = mix_w[31];
                mreq.a     = mag_w;
                mreq.b     = 32'(env_reg);
                state_next = ST_W8;
            end
            ST_W8: begin
                t_next     = wt_w;
                state_next = ST_W9;
            end
            ST_W9: begin
                x1lo_next    = wx_w[30:15];
                div_x_next   = 32'(wx_w[59:31]);
                div_sel_next = DIV_ENV;
                ret_next     = ST_W10;
                state_next   = ST_DQ;
            end
            ST_W10: begin
                qh_next    = q_reg[15:0];
                div_x_next = 32'({rem_reg[14:0], x1lo_reg});
                ret_next   = ST_W11;
                state_next = ST_DQ;
            end
            ST_W11: begin
                div_x_next   = {qh_reg, q_reg[15:0]};
                div_sel_next = DIV_GROWL_SCALE;
                ret_next     = ST_FIN;
                state_next   = ST_DQ;
            end

            // Apply sign, saturate and hand the sample to the output register.
            ST_FIN: begin
                if (out_free_w) begin
                    out_val_next = fin_w;
                    out_end_next = 1'b0;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath and output payload.
    always_ff @(posedge aclk) begin
        action_reg  <= action_next;
        index_reg   <= index_next;
        div_sel_reg <= div_sel_next;
        div_x_reg   <= div_x_next;
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        sidx_reg    <= sidx_next;
        x_reg       <= x_next;
        x2_reg      <= x2_next;
        quad_reg    <= quad_next;
        sin_reg     <= sin_next;
        k_reg       <= k_next;
        n_reg       <= n_next;
        y_reg       <= y_next;
        e_reg       <= e_next;
        env_reg     <= env_next;
        mneg_reg    <= mneg_next;
        plo_reg     <= plo_next;
        t_reg       <= t_next;
        x1lo_reg    <= x1lo_next;
        qh_reg      <= qh_next;
        out_val_reg <= out_val_next;
        out_end_reg <= out_end_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_sample_value = out_val_reg;
    assign m_past_end     = out_end_reg;

endmodule

`default_nettype wire

### hdl/psfx_checker.sv
// Port-level assertions for the synthesizer and the bind that attaches them.
`default_nettype none

module psfx_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               s_action,
    input wire logic [16:0]        s_sample_index,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [15:0] m_sample_value,
    input wire logic               m_past_end
);

    // A sample past the end of its sound is silent.
    a_past_end_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_past_end |-> m_sample_value == 16'sd0)
        else $error("past_end result with nonzero sample");

    // A stalled result holds its payload.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_value) && $stable(m_past_end))
        else $error("stalled result changed");

    // A waiting input transaction keeps its payload until it is taken.
    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_action) && $stable(s_sample_index))
        else $error("waiting input transaction changed");

    // The block is busy in the cycle after it takes a transaction.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a transaction");

    // Reset leaves the block idle with no result pending.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind procedural_sound_effect_synth psfx_checker u_psfx_checker (.*);

`default_nettype wire

### tb/sv/tb_procedural_sound_effect_synth.sv
// Testbench for the procedural sound-effect synthesizer: directed table, random samples, scoreboard.
`default_nettype none

module tb_procedural_sound_effect_synth;
    timeunit 1ns;
    timeprecision 1ps;

    import psfx_pkg::*;

    localparam int SINE_DEPTH = SINE_TABLE_DEPTH;
    localparam int EXP_DEPTH  = EXP_TABLE_DEPTH;
    localparam longint CYCLE_LIMIT = 2000000;

    // One predicted or observed sample.
    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       past_end;
    } sample_t;

    // One row of the directed table; has_fixed marks a result typed in by hand.
    typedef struct {
        logic                 action;
        logic [INDEX_W-1:0]   index;
        bit                   has_fixed;
        logic signed [15:0]   fixed_value;
        logic                 fixed_past;
    } dir_row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic s_action;
    logic [INDEX_W-1:0] s_sample_index;
    logic m_valid;
    logic m_ready;
    logic signed [SAMPLE_W-1:0] m_sample_value;
    logic m_past_end;

    logic [LFSR_W-1:0] noise_state;
    sample_t pending_samples[$];
    int error_count;
    int send_idle_pct;
    int recv_stall_pct;
    longint cycle_count;

    procedural_sound_effect_synth u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_sample_index (s_sample_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_value (m_sample_value),
        .m_past_end     (m_past_end)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Sine approximation at the table resolution, Q1.15.
    function automatic longint sine_q15(logic [31:0] phase);
        longint unsigned slot;
        longint unsigned turn;
        longint unsigned quad;
        longint x;
        longint x2;
        longint p;
        slot = ({32'd0, phase} * SINE_DEPTH) >> 32;
        turn = (slot * 65536) / SINE_DEPTH;
        quad = (turn >> 14) & 3;
        x = longint'(turn & 16'h3FFF);
        if (quad[0]) x = 16384 - x;
        x2 = (x * x) >>> 14;
        p = 42334 - ((5223 * x2) >>> 14);
        p = 102944 - ((p * x2) >>> 14);
        p = (((p * x) >>> 14) + 1) >>> 1;
        if (p > 32767) p = 32767;
        return (quad >= 2) ? -p : p;
    endfunction

    // Decay exp(-20t) at the table resolution, Q1.15.
    function automatic longint decay_q15(longint unsigned k);
        longint unsigned s;
        longint unsigned sh;
        longint y;
        longint p;
        longint v;
        s = (k * 1890969) / EXP_DEPTH;
        sh = s >> 16;
        y = longint'(s & 16'hFFFF);
        p = 15744 - ((3638 * y) >>> 16);
        p = 45426 - ((p * y) >>> 16);
        p = (p * y) >>> 16;
        v = 65536 - p;
        if (sh >= 32) return 0;
        v = ((v >>> sh) + 1) >>> 1;
        return (v > 32767) ? 32767 : v;
    endfunction

    // Advance the noise register and return noise in [-1000, 999].
    function automatic longint step_noise();
        logic out_bit;
        out_bit = noise_state[0];
        noise_state = noise_state >> 1;
        if (out_bit) noise_state = noise_state ^ LFSR_MASK;
        return longint'({1'b0, noise_state[30:0]} % 2000) - 1000;
    endfunction

    // Expected sample for one accepted transaction; steps the noise register.
    function automatic sample_t synth_sample(logic action, logic [INDEX_W-1:0] index);
        sample_t r;
        longint unsigned i;
        longint unsigned fq;
        logic [31:0] ph;
        longint s;
        longint s1;
        longint e;
        longint n;
        longint m;
        longint env;
        longint val;
        i = index;
        r.past_end = 1'b0;
        if (action == ACT_GUNSHOT) begin
            if (i >= 44100) begin
                r.value = '0;
                r.past_end = 1'b1;
                return r;
            end
            ph = 32'((((150 * i) % 44100) << 32) / 44100);
            s = sine_q15(ph);
            e = decay_q15((i * EXP_DEPTH) / 44100);
            n = step_noise();
            m = 8 * n * 32768 + s * 1000;
            val = (m * e * 32767) / (longint'(10000) * 32768 * 32768 * 2);
        end else begin
            if (i >= 88200) begin
                r.value = '0;
                r.past_end = 1'b1;
                return r;
            end
            s1 = sine_q15(32'(i * 46501));
            fq = longint'(80 * 65536) + 40 * s1;
            ph = 32'((fq * i * 65536) / 44100);
            s = sine_q15(ph);
            if (i < 4410) env = 5 * i;
            else if (i > 66150) env = 88200 - i;
            else env = 22050;
            n = step_noise();
            m = 6000 * s + 4 * n * 32768;
            val = (m * env * 98301) / (longint'(10000) * 32768 * 22050 * 10);
        end
        if (val > 32767) val = 32767;
        if (val < -32768) val = -32768;
        r.value = 16'(val);
        return r;
    endfunction

    // Drive one transaction and hold it until accepted; queue its expectation.
    task automatic send_sample(logic action, logic [INDEX_W-1:0] index,
                               bit has_fixed, logic signed [15:0] fv, logic fp);
        sample_t exp_s;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= action;
        s_sample_index <= index;
        do @(posedge aclk); while (!s_ready);
        exp_s = synth_sample(action, index);
        if (has_fixed) begin
            exp_s.value = fv;
            exp_s.past_end = fp;
        end
        pending_samples.push_back(exp_s);
    endtask

    // Stop sending and wait until every expected sample has come back.
    task automatic drain_samples();
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
    endtask

    // Pick a random index, biased toward the envelope edges and sound ends.
    function automatic logic [INDEX_W-1:0] pick_index(logic action);
        int sel;
        sel = $urandom_range(99);
        if (sel < 5) return 17'($urandom_range(131071, 88200));
        if (sel < 10) return action ? 17'($urandom_range(88199, 88100))
                                    : 17'($urandom_range(44199, 44000));
        if (sel < 20) return 17'($urandom_range(4500, 0));
        if (sel < 25) return 17'($urandom_range(66300, 66000));
        return action ? 17'($urandom_range(88199)) : 17'($urandom_range(44099));
    endfunction

    // Output side: random stalls and comparison against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_samples.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected sample: value %0d past_end %0b",
                                 m_sample_value, m_past_end);
                end else begin
                    sample_t want;
                    want = pending_samples.pop_front();
                    if (want.value !== m_sample_value || want.past_end !== m_past_end) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("sample mismatch: expected %0d/%0b got %0d/%0b",
                                     want.value, want.past_end,
                                     m_sample_value, m_past_end);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_procedural_sound_effect_synth: errors");
            $finish;
        end
    end

    // Directed table, then random phases with varying idle patterns.
    initial begin
        dir_row_t rows[$];
        int idle_phase[4][2];
        noise_state = LFSR_SEED;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = 1'b0;
        s_sample_index = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows = '{
            '{ACT_GUNSHOT, 17'd0,      0, 16'sd0, 1'b0},
            '{ACT_GROWL,   17'd0,      1, 16'sd0, 1'b0},
            '{ACT_GUNSHOT, 17'd1,      0, 16'sd0, 1'b0},
            '{ACT_GUNSHOT, 17'd44099,  0, 16'sd0, 1'b0},
            '{ACT_GUNSHOT, 17'd44100,  1, 16'sd0, 1'b1},
            '{ACT_GUNSHOT, 17'd131071, 1, 16'sd0, 1'b1},
            '{ACT_GROWL,   17'd88199,  0, 16'sd0, 1'b0},
            '{ACT_GROWL,   17'd88200,  1, 16'sd0, 1'b1},
            '{ACT_GROWL,   17'd131071, 1, 16'sd0, 1'b1},
            '{ACT_GROWL,   17'd4409,   0, 16'sd0, 1'b0},
            '{ACT_GROWL,   17'd4410,   0, 16'sd0, 1'b0},
            '{ACT_GROWL,   17'd66150,  0, 16'sd0, 1'b0},
            '{ACT_GROWL,   17'd66151,  0, 16'sd0, 1'b0},
            '{ACT_GROWL,   17'd30000,  0, 16'sd0, 1'b0},
            '{ACT_GUNSHOT, 17'd294,    0, 16'sd0, 1'b0},
            '{ACT_GUNSHOT, 17'd65535,  1, 16'sd0, 1'b1},
            '{ACT_GROWL,   17'd65536,  0, 16'sd0, 1'b0}
        };
        foreach (rows[k])
            send_sample(rows[k].action, rows[k].index, rows[k].has_fixed,
                        rows[k].fixed_value, rows[k].fixed_past);

        // Hold off until the directed results have all returned.
        drain_samples();

        idle_phase = '{'{0, 0}, '{48, 0}, '{0, 48}, '{23, 23}};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_phase[ph][0];
            recv_stall_pct = idle_phase[ph][1];
            for (int k = 0; k < 220; k++) begin
                logic act;
                act = 1'($urandom_range(1));
                send_sample(act, pick_index(act), 0, 16'sd0, 1'b0);
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain_samples();
        repeat (100) @(posedge aclk);
        if (error_count == 0)
            $display("tb_procedural_sound_effect_synth: clean");
        else
            $display("tb_procedural_sound_effect_synth: errors");
        $finish;
    end

endmodule

`default_nettype wire
